// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the hasher modules.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/sha256_pkg.sv =====
// Package for the SHA-256 stream hasher: constants, types, round functions.
// Used by the controller, datapath and top level.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       buf_we;
    logic [5:0] buf_addr;
    logic [1:0] buf_src;    // 0 data byte, 1 pad byte, 2 zero, 3 length byte
    logic       bits_inc;
    logic       load_vars;
    logic       do_round;
    logic [5:0] round_idx;
    logic       update_hash;
    logic       reset_hash;
    logic       word_rd;    // read schedule word source
  } dp_cmd_t;

  localparam logic [1:0] SrcData = 2'd0;
  localparam logic [1:0] SrcPad  = 2'd1;
  localparam logic [1:0] SrcZero = 2'd2;
  localparam logic [1:0] SrcLen  = 2'd3;

  function automatic word_t hash_init(input logic [2:0] i);
    unique case (i)
      3'd0: hash_init = 32'h6a09e667;
      3'd1: hash_init = 32'hbb67ae85;
      3'd2: hash_init = 32'h3c6ef372;
      3'd3: hash_init = 32'ha54ff53a;
      3'd4: hash_init = 32'h510e527f;
      3'd5: hash_init = 32'h9b05688c;
      3'd6: hash_init = 32'h1f83d9ab;
      default: hash_init = 32'h5be0cd19;
    endcase
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ===== rtl/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher, top level.
// Depends on sha256_pkg, sha256_ctrl, sha256_dp.
//
// Input channel: in_valid/in_stall with cmd and data_byte. cmd 0 absorbs
// data_byte into the message; cmd 1 pads the message and emits the digest.
// Output channel: out_valid/out_stall with digest_word, word_index, last_word.
// A finish gives eight items, words 0..7; last_word marks word 7.
// An absorb is a single buffer write, except the byte that fills a 64-byte
// block, which then runs a load step, 129 round-sequencer steps (each of the
// first 16 rounds waits for four bytes from the single-read block RAM)
// and a hash update step.
// A finish takes the padding writes (one per byte left in the block, and 64
// more before a second block), one or two block compressions, then the
// digest words. In that time in_stall stays high.
// A stalled output holds the current word; the next word follows the cycle
// after it is taken. After word 7 the hash returns to the initial values
// and the length count to zero.
// Reset (rst, synchronous) clears the controller, the length count and the
// hash words; the block buffer needs no clearing.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  sha256_pkg::dp_cmd_t dp_cmd;
  logic [2:0] sel;
  logic [5:0] rd_addr;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd_in(cmd),
    .out_stall(out_stall), .out_valid(out_valid), .out_sel(sel), .rd_addr(rd_addr),
    .cmd(dp_cmd)
  );

  sha256_dp u_dp (
    .clk(clk), .rst(rst), .cmd(dp_cmd), .data_byte(data_byte), .rd_addr(rd_addr),
    .out_sel(sel), .out_word(digest_word)
  );

  assign word_index = sel;
  assign last_word  = (sel == 3'd7);
endmodule

// ===== rtl/sha256_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module sha256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sha256_dp.sv =====
// Datapath: block buffer RAM, message length, schedule, round unit, hash words.
// Depends on sha256_pkg and sha256_ram.
`include "assert_macros.svh"
module sha256_dp (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::dp_cmd_t cmd,
  input  logic [7:0]          data_byte,
  input  logic [5:0]          rd_addr,
  input  logic [2:0]          out_sel,
  output sha256_pkg::word_t   out_word
);
  sha256_pkg::word_t hash [8];
  sha256_pkg::word_t wv [8];
  sha256_pkg::word_t sched [16];
  logic [63:0] message_bits;
  logic [7:0]  wdata, rdata;
  sha256_pkg::word_t wacc;      // big-endian word assembled from bytes
  sha256_pkg::word_t w_cur, s0, s1, t1, t2, ch, maj, bs0, bs1;
  logic [3:0] ti;

  // Byte to write into the block buffer.
  always_comb begin
    case (cmd.buf_src)
      sha256_pkg::SrcData: wdata = data_byte;
      sha256_pkg::SrcPad:  wdata = sha256_pkg::PadByte;
      sha256_pkg::SrcZero: wdata = 8'd0;
      default: wdata = message_bits[(7 - cmd.buf_addr[2:0]) * 8 +: 8];
    endcase
  end

  sha256_ram #(.Width(8), .Depth(64)) u_buf (
    .clk(clk), .we(cmd.buf_we), .waddr(cmd.buf_addr), .wdata(wdata),
    .raddr(rd_addr), .rdata(rdata)
  );

  // Length counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.reset_hash) message_bits <= '0;
    else if (cmd.bits_inc) message_bits <= message_bits + 64'd8;
  end

  // Byte shifter for schedule words, one byte per cycle while word_rd is set.
  always_ff @(posedge clk) begin
    if (cmd.word_rd) wacc <= {wacc[23:0], rdata};
  end

  // Schedule word and round functions for this round.
  assign ti = cmd.round_idx[3:0];
  always_comb begin
    s1 = sha256_pkg::rotr(sched[ti - 4'd2], 17) ^ sha256_pkg::rotr(sched[ti - 4'd2], 19)
       ^ (sched[ti - 4'd2] >> 10);
    s0 = sha256_pkg::rotr(sched[ti - 4'd15], 7) ^ sha256_pkg::rotr(sched[ti - 4'd15], 18)
       ^ (sched[ti - 4'd15] >> 3);
    w_cur = (cmd.round_idx < 6'd16) ? wacc : s1 + sched[ti - 4'd7] + s0 + sched[ti];
    bs1 = sha256_pkg::rotr(wv[4], 6) ^ sha256_pkg::rotr(wv[4], 11)
        ^ sha256_pkg::rotr(wv[4], 25);
    ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    t1  = wv[7] + bs1 + ch + sha256_pkg::RoundK[cmd.round_idx] + w_cur;
    bs0 = sha256_pkg::rotr(wv[0], 2) ^ sha256_pkg::rotr(wv[0], 13)
        ^ sha256_pkg::rotr(wv[0], 22);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t2  = bs0 + maj;
  end

  // Round registers.
  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int v = 0; v < 8; v++) wv[v] <= hash[v];
    end else if (cmd.do_round) begin
      sched[ti] <= w_cur;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  // Chaining words.
  always_ff @(posedge clk) begin
    if (rst || cmd.reset_hash) begin
      for (int v = 0; v < 8; v++) hash[v] <= sha256_pkg::hash_init(3'(v));
    end else if (cmd.update_hash) begin
      for (int v = 0; v < 8; v++) hash[v] <= hash[v] + wv[v];
    end
  end

  assign out_word = hash[out_sel];

  `ASSERT_IMPL(a_round_excl, clk, rst, cmd.do_round, !cmd.load_vars && !cmd.update_hash)
  `ASSERT_NEXT(a_bits_step, clk, rst, cmd.bits_inc && !cmd.reset_hash,
               message_bits == $past(message_bits) + 64'd8)
  `ASSERT_NEXT(a_hash_reset, clk, rst, cmd.reset_hash, hash[0] == 32'h6a09e667)
endmodule

// ===== rtl/sha256_ctrl.sv =====
// Controller: accepts items, sequences buffer writes, padding, rounds, digest output.
// Depends on sha256_pkg.
`include "assert_macros.svh"
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd_in,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          out_sel,
  output logic [5:0]          rd_addr,
  output sha256_pkg::dp_cmd_t cmd
);
  sha256_pkg::state_t state, state_next;
  logic [5:0] fill, fill_next;
  logic [7:0] cnt, cnt_next;      // load/round step counter
  logic [2:0] ph, ph_next;        // step within a five-step word fetch
  logic [4:0] grp, grp_next;      // word fetch group, 0..16
  logic       fin, fin_next;      // finishing message
  logic       last, last_next;    // current pad block holds the length
  logic [2:0] osel, osel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      fill <= '0; cnt <= '0; ph <= '0; grp <= '0; fin <= 1'b0; last <= 1'b0;
      osel <= '0;
    end else begin
      state <= state_next;
      fill <= fill_next; cnt <= cnt_next; ph <= ph_next; grp <= grp_next;
      fin <= fin_next; last <= last_next;
      osel <= osel_next;
    end
  end

  assign out_sel = osel;

  // Rounds 0..15 each take four byte reads and one round step: round r runs
  // at cnt = 5*(r+1), so round 15 lands at cnt 80. Rounds 16..63 follow one
  // per cycle at cnt 81..128.
  always_comb begin
    state_next = state;
    fill_next = fill; cnt_next = cnt; fin_next = fin; last_next = last;
    ph_next = ph; grp_next = grp;
    osel_next = osel;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    rd_addr = '0;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (cmd_in == sha256_pkg::CmdAbsorb) begin
            cmd.buf_we = 1'b1; cmd.buf_addr = fill; cmd.buf_src = sha256_pkg::SrcData;
            cmd.bits_inc = 1'b1;
            fill_next = fill + 6'd1;
            if (fill == 6'd63) begin
              state_next = sha256_pkg::ST_LOAD; fin_next = 1'b0;
            end
          end else begin
            cmd.buf_we = 1'b1; cmd.buf_addr = fill; cmd.buf_src = sha256_pkg::SrcPad;
            fill_next = fill + 6'd1;
            fin_next = 1'b1;
            last_next = (fill < 6'd56);
            state_next = (fill == 6'd63) ? sha256_pkg::ST_LOAD : sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        // Zero up to the length field, then the length; all zeros on a long tail.
        cmd.buf_we = 1'b1; cmd.buf_addr = fill;
        cmd.buf_src = (last && fill >= sha256_pkg::LenPos) ? sha256_pkg::SrcLen
                                                           : sha256_pkg::SrcZero;
        fill_next = fill + 6'd1;
        if (fill == 6'd63) state_next = sha256_pkg::ST_LOAD;
      end
      sha256_pkg::ST_LOAD: begin
        cmd.load_vars = 1'b1;
        cnt_next = '0;
        ph_next = '0;
        grp_next = '0;
        state_next = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        // cnt 0..79 fetches the sixteen block words and runs rounds 0..14.
        if (cnt < 8'd80) begin
          rd_addr = {grp[3:0], 2'b00} + {3'b000, ph};
          cmd.word_rd = (ph != 3'd0);
          cmd.do_round = (ph == 3'd0) && (grp != 5'd0);
          cmd.round_idx = {1'b0, grp} - 6'd1;
          if (ph == 3'd4) begin
            ph_next = '0;
            grp_next = grp + 5'd1;
          end else begin
            ph_next = ph + 3'd1;
          end
        end else begin
          cmd.do_round = 1'b1;
          cmd.round_idx = 6'(cnt - 8'd65);
        end
        cnt_next = cnt + 8'd1;
        if (cnt == 8'd128) state_next = sha256_pkg::ST_UPDATE;
      end
      sha256_pkg::ST_UPDATE: begin
        cmd.update_hash = 1'b1;
        if (!fin) state_next = sha256_pkg::ST_IDLE;
        else if (last) begin
          state_next = sha256_pkg::ST_EMIT; osel_next = '0;
        end else begin
          last_next = 1'b1; state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          osel_next = osel + 3'd1;
          if (osel == 3'd7) begin
            cmd.reset_hash = 1'b1; fin_next = 1'b0; fill_next = '0;
            state_next = sha256_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_stall_busy, clk, rst, state != sha256_pkg::ST_IDLE, in_stall)
  `ASSERT_IMPL(a_emit_fin, clk, rst, out_valid, fin && last)
  `ASSERT_IMPL(a_fill_zero_emit, clk, rst, out_valid, fill == 6'd0)
endmodule

// ===== dv/tb_sha256_stream_hasher_core.sv =====
`timescale 1ns / 1ps
// Testbench for the SHA-256 stream hasher core: byte messages in, digest words out.
// Depends on sha256_pkg and sha256_stream_hasher_core; holds its own SHA-256 predictor.

// Digest predictor and scoreboard of expected digest words.
class sha_digest_board;
  sha256_pkg::word_t chain [8];
  byte     blk [64];
  int      fill;
  longint unsigned nbits;
  sha256_pkg::word_t exp_word [$];
  bit [2:0] exp_idx [$];
  bit      exp_last [$];
  int      errors;

  function new();
    restart();
    errors = 0;
  endfunction

  function void restart();
    chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill = 0;
    nbits = 0;
  endfunction

  function sha256_pkg::word_t ror(sha256_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    sha256_pkg::word_t v [8];
    sha256_pkg::word_t w [64];
    sha256_pkg::word_t t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end else begin
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] += t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  // Note an accepted input item.
  function void note_item(bit c, byte d);
    if (c == sha256_pkg::CmdAbsorb) begin
      blk[fill] = d;
      nbits += 8;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
      return;
    end
    blk[fill++] = sha256_pkg::PadByte;
    if (fill > 56) begin
      while (fill < 64) blk[fill++] = 0;
      compress();
      fill = 0;
    end
    while (fill < 56) blk[fill++] = 0;
    for (int i = 0; i < 8; i++) blk[56+i] = byte'(nbits >> (56 - 8*i));
    compress();
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(chain[i]);
      exp_idx.push_back(3'(i));
      exp_last.push_back(i == 7);
    end
    restart();
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Check one accepted digest word against the oldest expectation.
  task check_word(sha256_pkg::word_t dw, bit [2:0] ix, bit lw);
    sha256_pkg::word_t ew;
    bit [2:0] ei;
    bit el;
    if (exp_word.size() == 0) begin
      report($sformatf("unexpected word %h idx %0d", dw, ix));
      return;
    end
    ew = exp_word.pop_front();
    ei = exp_idx.pop_front();
    el = exp_last.pop_front();
    if (dw !== ew) report($sformatf("digest_word %h, want %h", dw, ew));
    if (ix !== ei) report($sformatf("word_index %0d, want %0d", ix, ei));
    if (lw !== el) report($sformatf("last_word %b, want %b", lw, el));
  endtask
endclass

module tb_sha256_stream_hasher_core;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic cmd = 0;
  logic [7:0] data_byte = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] digest_word;
  logic [2:0] word_index;
  logic last_word;

  sha_digest_board board = new();
  int cycles = 0;
  bit hold_off = 0;
  localparam int CycleLimit = 400000;

  sha256_stream_hasher_core uut (.*);

  always #5 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output sampling and receiver stall pattern.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_word(digest_word, word_index, last_word);
    if (hold_off) out_stall <= 1;
    else if (cycles % 400 < 150) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Send one item; returns after it is accepted.
  task automatic send_item(bit c, logic [7:0] d);
    in_valid <= 1;
    cmd <= c;
    data_byte <= d;
    do @(posedge clk); while (in_stall);
    board.note_item(c, d);
  endtask

  task automatic idle_sender(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (board.exp_word.size() != 0) @(posedge clk);
  endtask

  // Message of n random bytes then a finish, sent in bursts.
  task automatic send_message(int n);
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      send_item(sha256_pkg::CmdAbsorb, 8'($urandom));
      if (--burst == 0) begin
        if ($urandom_range(0, 1)) idle_sender($urandom_range(1, 5));
        burst = $urandom_range(1, 20);
      end
    end
    send_item(sha256_pkg::CmdFinish, 8'($urandom));
  endtask

  initial begin
    int n;
    int tails [3];
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty message, stray data on finish, "abc", extreme bytes.
    send_item(sha256_pkg::CmdFinish, 8'hff);
    send_item(sha256_pkg::CmdAbsorb, 8'h61);
    send_item(sha256_pkg::CmdAbsorb, 8'h62);
    send_item(sha256_pkg::CmdAbsorb, 8'h63);
    send_item(sha256_pkg::CmdFinish, 8'h00);
    send_item(sha256_pkg::CmdAbsorb, 8'h00);
    send_item(sha256_pkg::CmdAbsorb, 8'hff);
    send_item(sha256_pkg::CmdAbsorb, 8'haa);
    send_item(sha256_pkg::CmdAbsorb, 8'h55);
    send_item(sha256_pkg::CmdFinish, 8'h00);
    wait_drained();
    // Long hold-off: receiver stalls while sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_message(3);
        send_message(0);
        send_message(5);
      end
    join
    wait_drained();
    // Tails at the two-block padding edge, a full last byte, a full block.
    tails = '{56, 63, 64};
    foreach (tails[k]) send_message(tails[k]);
    wait_drained();
    // A few short random messages.
    for (int m = 0; m < 3; m++) begin
      n = $urandom_range(0, 8);
      send_message(n);
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 30));
    end
    wait_drained();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.exp_word.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_ram.sv
rtl/sha256_dp.sv
rtl/sha256_ctrl.sv
rtl/sha256_stream_hasher_core.sv
dv/tb_sha256_stream_hasher_core.sv
